// ===== hw/rtl/cbm_pkg.sv =====
package cbm_pkg;

  localparam int PIX_W          = 16;
  localparam int OUT_W          = 20;
  localparam int FRAC_W         = 4;
  localparam int WIN_CFG_W      = 5;
  localparam int IMG_CFG_W      = 11;
  localparam int WIN_RESET      = 3;
  localparam int IMG_RESET      = 640;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_WINDOW = 16;
  localparam int DEF_DIV_W      = 28;
  localparam int DEF_CNT_W      = 9;
  localparam int SUM_LANES      = 4;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int REG_IDX_LSB    = 2;

  typedef enum logic {
    REG_WINDOW_SIZE,
    REG_IMAGE_WIDTH
  } cbm_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MERGE,
    ST_COLSUM,
    ST_STORE,
    ST_WINSUM,
    ST_START,
    ST_DIV,
    ST_OUT
  } cbm_state_t;

  typedef struct packed {
    logic start;
    logic neg;
  } cbm_div_ctl_t;

endpackage

// ===== hw/rtl/cbm_div.sv =====
module cbm_div #(
  parameter int DIV_W = cbm_pkg::DEF_DIV_W,
  parameter int CNT_W = cbm_pkg::DEF_CNT_W
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cbm_pkg::cbm_div_ctl_t              ctl,
  input  logic [DIV_W-1:0]                   dividend,
  input  logic [CNT_W-1:0]                   divisor,
  output logic                               busy,
  output logic signed [cbm_pkg::OUT_W-1:0]   quotient
);
  import cbm_pkg::*;

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  div_r;
  logic [STEP_W-1:0] step_r;
  logic              neg_r;
  logic              busy_r;

  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_diff;
  logic              sub_ok;
  logic [OUT_W-1:0]  q_lo;

  // restoring long division, one quotient bit per cycle; quotient bits
  // shift into the dividend register from the bottom
  always_comb begin
    rem_sh   = {rem_r, quo_r[DIV_W-1]};
    rem_diff = rem_sh - {1'b0, div_r};
    sub_ok   = rem_sh >= {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      step_r <= STEP_W'(DIV_W);
    end else if (busy_r) begin
      step_r <= step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
      neg_r <= ctl.neg;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], sub_ok};
      rem_r <= sub_ok ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  // magnitude stays within OUT_W bits, so truncating before negation is exact
  always_comb begin
    q_lo     = quo_r[OUT_W-1:0];
    quotient = neg_r ? -signed'(q_lo) : signed'(q_lo);
  end

  assign busy = busy_r;

endmodule

// ===== hw/rtl/causal_box_mean_filter.sv =====
// Causal box mean over a disparity stream.
//
// Input beats (in_valid/in_stall) carry one pixel each in raster order;
// in_frame_start marks the first pixel of an image. Every input beat
// produces exactly one output beat (out_valid/out_stall) holding the mean
// of the window of up to W x W pixels ending at that pixel, clipped at the
// top and left edges, scaled by 16 and truncated toward zero.
// Configuration goes through the APB port: window_size at 0x0, image_width
// at 0x4. Write only while the block is idle.
//
// One pixel is in flight at a time. Each pixel goes through a line-store
// read-modify-write, two four-lane adder passes and a bit-serial divide of
// sum/count that is DIV_W = 20 + 2*log2(MAX_WINDOW) bits wide.
// The result sits in an output register, so a stalled receiver only holds
// up the next pixel once its own result is ready to be loaded.
//
// Reset puts the registers back to 3 and 640, clears position and
// output state. The line store needs no clearing pass.
module causal_box_mean_filter #(
  parameter int MAX_WIDTH  = cbm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_WINDOW = cbm_pkg::DEF_MAX_WINDOW
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [cbm_pkg::PIX_W-1:0]     in_pixel_value,
  input  logic                                 in_frame_start,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [cbm_pkg::OUT_W-1:0]     out_mean_value,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cbm_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [cbm_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [cbm_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready
);
  import cbm_pkg::*;

  localparam int CI_W   = $clog2(MAX_WIDTH);
  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int RS_W   = $clog2(MAX_WINDOW + 1);
  localparam int CSW    = PIX_W + $clog2(MAX_WINDOW);
  localparam int WSW    = CSW + $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int DIV_W  = WSW + FRAC_W;
  localparam int NG     = (MAX_WINDOW + SUM_LANES - 1) / SUM_LANES;
  localparam int NL     = NG * SUM_LANES;
  localparam int GRP_W  = (NG > 1) ? $clog2(NG) : 1;
  localparam int CMP_A  = (CI_W > RS_W) ? CI_W : RS_W;
  localparam int CMP_W  = ((CMP_A > WIN_CFG_W) ? CMP_A : WIN_CFG_W) + 1;
  localparam int MW_W   = $clog2(MAX_WIDTH + 1);
  localparam int XW     = ((IMG_CFG_W > MW_W) ? IMG_CFG_W : MW_W) + 1;
  localparam int WORD_W = MAX_WINDOW * PIX_W;

  // ring distance from head back to lane e
  function automatic logic [SLOT_W-1:0] ring_dist(logic [SLOT_W-1:0] head, int e);
    logic [SLOT_W:0] wrap;
    wrap = {1'b0, head} + (SLOT_W+1)'(MAX_WINDOW) - (SLOT_W+1)'(e);
    if (head >= SLOT_W'(e)) begin
      return head - SLOT_W'(e);
    end
    return wrap[SLOT_W-1:0];
  endfunction

  // configuration
  logic [WIN_CFG_W-1:0] win_cfg_r;
  logic [IMG_CFG_W-1:0] img_cfg_r;
  logic                 cfg_wr;
  cbm_reg_t             cfg_idx;

  // position in the frame
  logic [CI_W-1:0]   col_idx_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] ptr_r;
  logic [RS_W-1:0]   rows_seen_r;

  // item in flight
  logic signed [PIX_W-1:0] pix_r;
  logic [CI_W-1:0]         cur_col_r;
  logic [SLOT_W-1:0]       cur_slot_r;
  logic [SLOT_W-1:0]       cur_ptr_r;
  logic [RS_W-1:0]         rows_r;
  logic [RS_W-1:0]         cols_r;
  logic [CNT_W-1:0]        count_r;

  cbm_state_t state_r, state_nxt;
  logic       in_accept;
  logic       mem_rd, mem_wr, out_load;

  logic [CI_W-1:0]   col_eff;
  logic [SLOT_W-1:0] slot_eff, ptr_eff;
  logic [RS_W-1:0]   rs_eff;
  logic [CMP_W-1:0]  win_ext, w_eff, rs_ext, col_ext;
  logic [CMP_W-1:0]  rows_c, cols_c;
  logic [XW-1:0]     img_x, wid_eff, col_next_x;
  logic              row_end;

  logic [WORD_W-1:0] line_mem [MAX_WIDTH];
  logic [WORD_W-1:0] rd_word_r;
  logic [WORD_W-1:0] merged_word;

  logic signed [CSW-1:0] recent_r [MAX_WINDOW];
  logic signed [CSW-1:0] lanes_r  [NL];
  logic signed [CSW-1:0] row_lane [NL];
  logic signed [CSW-1:0] win_lane [NL];
  logic signed [CSW-1:0] lane_shift [NL];
  logic signed [WSW-1:0] acc_r;
  logic signed [WSW-1:0] grp_sum;
  logic [GRP_W-1:0]      grp_r;
  logic                  grp_last;

  logic [WSW-1:0]        acc_mag;
  logic [DIV_W-1:0]      div_dividend;
  cbm_div_ctl_t          div_ctl;
  logic                  div_busy;
  logic signed [OUT_W-1:0] div_mean;

  logic                  out_valid_r;
  logic signed [OUT_W-1:0] out_mean_r;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = cbm_reg_t'(paddr[REG_IDX_LSB]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cfg_r <= WIN_CFG_W'(WIN_RESET);
      img_cfg_r <= IMG_CFG_W'(IMG_RESET);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WINDOW_SIZE: win_cfg_r <= pwdata[WIN_CFG_W-1:0];
        REG_IMAGE_WIDTH: img_cfg_r <= pwdata[IMG_CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WINDOW_SIZE: prdata = CFG_DATA_W'(win_cfg_r);
      REG_IMAGE_WIDTH: prdata = CFG_DATA_W'(img_cfg_r);
    endcase
  end

  // ---------------- position and spans ----------------
  always_comb begin
    col_eff  = in_frame_start ? '0 : col_idx_r;
    slot_eff = in_frame_start ? '0 : slot_r;
    ptr_eff  = in_frame_start ? '0 : ptr_r;
    rs_eff   = in_frame_start ? '0 : rows_seen_r;

    win_ext = CMP_W'(win_cfg_r);
    if (win_ext == '0) begin
      w_eff = CMP_W'(1);
    end else if (win_ext > CMP_W'(MAX_WINDOW)) begin
      w_eff = CMP_W'(MAX_WINDOW);
    end else begin
      w_eff = win_ext;
    end

    rs_ext  = CMP_W'(rs_eff);
    col_ext = CMP_W'(col_eff);
    rows_c  = (rs_ext >= w_eff) ? w_eff : rs_ext + CMP_W'(1);
    cols_c  = (col_ext >= w_eff) ? w_eff : col_ext + CMP_W'(1);

    img_x = XW'(img_cfg_r);
    if (img_x == '0) begin
      wid_eff = XW'(1);
    end else if (img_x > XW'(MAX_WIDTH)) begin
      wid_eff = XW'(MAX_WIDTH);
    end else begin
      wid_eff = img_x;
    end
    col_next_x = XW'(col_eff) + XW'(1);
    // also ends the row when the width was lowered below the current column
    row_end    = col_next_x >= wid_eff;
  end

  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_idx_r   <= '0;
      slot_r      <= '0;
      ptr_r       <= '0;
      rows_seen_r <= '0;
    end else if (in_accept) begin
      if (row_end) begin
        col_idx_r   <= '0;
        ptr_r       <= '0;
        slot_r      <= (slot_eff == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot_eff + SLOT_W'(1);
        rows_seen_r <= (rs_eff < RS_W'(MAX_WINDOW)) ? rs_eff + RS_W'(1) : rs_eff;
      end else begin
        col_idx_r   <= col_eff + CI_W'(1);
        slot_r      <= slot_eff;
        ptr_r       <= (ptr_eff == SLOT_W'(MAX_WINDOW - 1)) ? '0 : ptr_eff + SLOT_W'(1);
        rows_seen_r <= rs_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pix_r      <= in_pixel_value;
      cur_col_r  <= col_eff;
      cur_slot_r <= slot_eff;
      cur_ptr_r  <= ptr_eff;
      rows_r     <= rows_c[RS_W-1:0];
      cols_r     <= cols_c[RS_W-1:0];
    end
  end

  // ---------------- sequencer ----------------
  assign grp_last = grp_r == GRP_W'(NG - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_stall      = 1'b1;
    mem_rd        = 1'b0;
    mem_wr        = 1'b0;
    out_load      = 1'b0;
    div_ctl.start = 1'b0;
    div_ctl.neg   = acc_r[WSW-1];
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_nxt = ST_READ;
      end
      ST_READ: begin
        mem_rd    = 1'b1;
        state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        mem_wr    = 1'b1;
        state_nxt = ST_COLSUM;
      end
      ST_COLSUM: begin
        if (grp_last) state_nxt = ST_STORE;
      end
      ST_STORE: begin
        state_nxt = ST_WINSUM;
      end
      ST_WINSUM: begin
        if (grp_last) state_nxt = ST_START;
      end
      ST_START: begin
        div_ctl.start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  // ---------------- line store: one word per column, one lane per row slot --
  always_ff @(posedge clk) begin
    if (mem_wr) line_mem[cur_col_r] <= merged_word;
    if (mem_rd) rd_word_r <= line_mem[cur_col_r];
  end

  // ---------------- lane selection ----------------
  always_comb begin
    logic signed [PIX_W-1:0] lane_pix;
    logic signed [CSW-1:0]   lane_col;
    for (int e = 0; e < NL; e++) begin
      row_lane[e] = '0;
      win_lane[e] = '0;
    end
    for (int e = 0; e < MAX_WINDOW; e++) begin
      lane_pix = (SLOT_W'(e) == cur_slot_r) ? pix_r : signed'(rd_word_r[e*PIX_W +: PIX_W]);
      merged_word[e*PIX_W +: PIX_W] = lane_pix;
      if (RS_W'(ring_dist(cur_slot_r, e)) < rows_r) begin
        row_lane[e] = CSW'(lane_pix);
      end
      // freshly formed column sum joins the recent ones
      lane_col = (SLOT_W'(e) == cur_ptr_r) ? signed'(acc_r[CSW-1:0]) : recent_r[e];
      if (RS_W'(ring_dist(cur_ptr_r, e)) < cols_r) begin
        win_lane[e] = lane_col;
      end
    end
    for (int i = 0; i < NL; i++) begin
      lane_shift[i] = '0;
    end
    for (int i = 0; i < NL - SUM_LANES; i++) begin
      lane_shift[i] = lanes_r[i + SUM_LANES];
    end
    grp_sum = '0;
    for (int i = 0; i < SUM_LANES; i++) begin
      grp_sum = grp_sum + WSW'(lanes_r[i]);
    end
  end

  // ---------------- accumulation passes ----------------
  always_ff @(posedge clk) begin
    case (state_r)
      ST_MERGE: begin
        lanes_r <= row_lane;
        acc_r   <= '0;
        grp_r   <= '0;
        count_r <= CNT_W'(rows_r) * CNT_W'(cols_r);
      end
      ST_STORE: begin
        lanes_r <= win_lane;
        acc_r   <= '0;
        grp_r   <= '0;
      end
      ST_COLSUM, ST_WINSUM: begin
        lanes_r <= lane_shift;
        acc_r   <= acc_r + grp_sum;
        grp_r   <= grp_r + GRP_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < MAX_WINDOW; e++) begin
        recent_r[e] <= '0;
      end
    end else if (state_r == ST_STORE) begin
      recent_r[cur_ptr_r] <= signed'(acc_r[CSW-1:0]);
    end
  end

  // ---------------- divide ----------------
  assign acc_mag      = acc_r[WSW-1] ? WSW'(-acc_r) : acc_r;
  assign div_dividend = {acc_mag, FRAC_W'(0)};

  cbm_div #(
    .DIV_W (DIV_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (count_r),
    .busy     (div_busy),
    .quotient (div_mean)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_mean_r <= div_mean;
  end

  assign out_valid      = out_valid_r;
  assign out_mean_value = out_mean_r;

endmodule

// ===== hw/rtl/cbm_chk.sv =====
module cbm_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [cbm_pkg::OUT_W-1:0]  out_mean_value,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [cbm_pkg::CFG_ADDR_W-1:0]    paddr,
  input logic [cbm_pkg::CFG_DATA_W-1:0]    pwdata,
  input logic [cbm_pkg::CFG_DATA_W-1:0]    prdata
);
  import cbm_pkg::*;

  // one pixel in flight: the beat after an accept is always held off
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a pixel is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mean_value))
    else $error("stalled result changed");

  // mean of 16-bit samples times 16 never exceeds 0x7fff0
  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_mean_value[OUT_W-1:FRAC_W] == 16'h7fff &&
                    out_mean_value[FRAC_W-1:0] != '0))
    else $error("mean outside sample range");

  a_win_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite &&
     cbm_reg_t'(paddr[REG_IDX_LSB]) == REG_WINDOW_SIZE)
    ##1 (cbm_reg_t'(paddr[REG_IDX_LSB]) == REG_WINDOW_SIZE)
    |-> prdata[WIN_CFG_W-1:0] == $past(pwdata[WIN_CFG_W-1:0]) &&
        prdata[CFG_DATA_W-1:WIN_CFG_W] == '0)
    else $error("window_size readback mismatch");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind causal_box_mean_filter cbm_chk u_cbm_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_mean_value (out_mean_value),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata)
);

// ===== verif/causal_box_mean_filter_tb.sv =====
module causal_box_mean_filter_tb;
  import cbm_pkg::*;

  localparam int LINE_LEN     = DEF_MAX_WIDTH;
  localparam int LINE_ROWS    = DEF_MAX_WINDOW;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 60;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [PIX_W-1:0]  in_pixel_value;
  logic                     in_frame_start;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [OUT_W-1:0]  out_mean_value;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_W-1:0]    paddr;
  logic [CFG_DATA_W-1:0]    pwdata;
  logic [CFG_DATA_W-1:0]    prdata;
  logic                     pready;

  causal_box_mean_filter u_dut (.*);

  always #10 clk = ~clk;

  // predictor copy of the filter state
  logic signed [PIX_W-1:0]  line_store [LINE_ROWS*LINE_LEN];
  logic signed [19:0]       recent_col_sums [LINE_ROWS];
  logic [WIN_CFG_W-1:0]     win_reg = WIN_CFG_W'(WIN_RESET);
  logic [IMG_CFG_W-1:0]     width_reg = IMG_CFG_W'(IMG_RESET);
  int unsigned              cur_col = 0;
  int unsigned              rows_done = 0;
  int unsigned              cur_slot = 0;

  logic signed [OUT_W-1:0]  pending_means [$];
  logic signed [OUT_W-1:0]  exp_mean;
  int                       errors = 0;
  int                       idle_cycles = 0;
  int                       snd_idle_pct = 0;
  int                       rcv_stall_pct = 0;

  initial begin
    for (int i = 0; i < LINE_ROWS; i++) recent_col_sums[i] = '0;
  end

  function automatic logic signed [OUT_W-1:0] predict_mean(logic signed [PIX_W-1:0] pix,
                                                           logic fs);
    int unsigned win, wd, rows, cols, c, k;
    logic signed [19:0] col_sum;
    logic signed [23:0] box_sum;
    longint scaled;
    win = (win_reg == 0) ? 1 : ((win_reg > LINE_ROWS) ? LINE_ROWS : win_reg);
    wd  = (width_reg == 0) ? 1 : ((width_reg > LINE_LEN) ? LINE_LEN : width_reg);
    if (fs) begin
      cur_col   = 0;
      rows_done = 0;
      cur_slot  = 0;
    end
    c = cur_col % LINE_LEN;
    line_store[cur_slot*LINE_LEN + c] = pix;
    rows = (rows_done + 1 > win) ? win : rows_done + 1;
    cols = (c + 1 > win) ? win : c + 1;
    col_sum = '0;
    for (k = 0; k < rows; k++)
      col_sum += line_store[((cur_slot + LINE_ROWS - k) % LINE_ROWS)*LINE_LEN + c];
    recent_col_sums[c % LINE_ROWS] = col_sum;
    box_sum = '0;
    for (k = 0; k < cols; k++)
      box_sum += recent_col_sums[(c - k) % LINE_ROWS];
    scaled = (longint'(box_sum) * 16) / longint'(rows * cols);
    // a column at or past the width (width lowered mid-row) also ends the row
    if (c + 1 >= wd) begin
      cur_col  = 0;
      cur_slot = (cur_slot + 1) % LINE_ROWS;
      if (rows_done < LINE_ROWS) rows_done++;
    end else begin
      cur_col = c + 1;
    end
    return scaled[OUT_W-1:0];
  endfunction

  function automatic logic signed [PIX_W-1:0] random_pixel();
    case ($urandom_range(9))
      0: return {1'b0, {(PIX_W-1){1'b1}}};
      1: return {1'b1, {(PIX_W-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic queue_expected(input logic signed [OUT_W-1:0] mean);
    pending_means = {pending_means, mean};
  endtask

  task automatic push_pixel(input logic signed [PIX_W-1:0] pix, input logic fs);
    int gap;
    gap = 0;
    if (snd_idle_pct != 0 && $urandom_range(99) < 3) gap = $urandom_range(1, 60);
    while ($urandom_range(99) < snd_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_value <= pix;
    in_frame_start <= fs;
    do @(posedge clk); while (in_stall);
    queue_expected(predict_mean(pix, fs));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cbm_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx) << REG_IDX_LSB;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WINDOW_SIZE) win_reg = val[WIN_CFG_W-1:0];
    else width_reg = val[IMG_CFG_W-1:0];
    @(posedge clk);
  endtask

  // reset values of both registers, no frame start
  task automatic test_reset_defaults();
    push_pixel(16'sh7fff, 1'b0);
    push_pixel(16'sh8000, 1'b0);
    push_pixel(16'sh0000, 1'b0);
  endtask

  task automatic test_full_scale_means();
    int i;
    wait_drained();
    write_reg(REG_WINDOW_SIZE, 2);
    write_reg(REG_IMAGE_WIDTH, 2);
    for (i = 0; i < 4; i++) push_pixel(16'sh8000, i == 0);
    for (i = 0; i < 4; i++) push_pixel(16'sh7fff, i == 0);
  endtask

  task automatic test_width_lowered_mid_row();
    int i;
    wait_drained();
    write_reg(REG_WINDOW_SIZE, 3);
    write_reg(REG_IMAGE_WIDTH, 4);
    for (i = 0; i < 6; i++) push_pixel(random_pixel(), i == 0);
    // column is now 2; new width 2 takes this beat at column 2 then wraps
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, 2);
    write_reg(REG_WINDOW_SIZE, 0);
    for (i = 0; i < 3; i++) push_pixel(random_pixel(), 1'b0);
  endtask

  task automatic test_size_limits();
    int i;
    wait_drained();
    write_reg(REG_WINDOW_SIZE, 31);
    write_reg(REG_IMAGE_WIDTH, 0);
    for (i = 0; i < 3; i++) push_pixel(random_pixel(), i == 0);
    wait_drained();
    write_reg(REG_WINDOW_SIZE, 16);
    write_reg(REG_IMAGE_WIDTH, 2047);
    for (i = 0; i < 3; i++) push_pixel(random_pixel(), i == 0);
  endtask

  task automatic test_random_frames(input int n_pixels, input int snd_pct, input int rcv_pct);
    int sent, frame_len, wd, win, width, i;
    sent = 0;
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    while (sent < n_pixels) begin
      wait_drained();
      win = ($urandom_range(4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
      case ($urandom_range(19))
        0:       width = 0;
        1:       width = LINE_LEN;
        2:       width = $urandom_range(LINE_LEN + 1, 2047);
        3:       width = $urandom_range(65, LINE_LEN - 1);
        4, 5, 6: width = $urandom_range(13, 64);
        default: width = $urandom_range(1, 12);
      endcase
      write_reg(REG_WINDOW_SIZE, win);
      write_reg(REG_IMAGE_WIDTH, width);
      wd = (width == 0) ? 1 : ((width > LINE_LEN) ? LINE_LEN : width);
      frame_len = wd * $urandom_range(1, 20);
      if (frame_len > 120) frame_len = $urandom_range(20, 120);
      for (i = 0; i < frame_len; i++) begin
        if (i != 0 && $urandom_range(99) < 2) wait_drained();
        push_pixel(random_pixel(), i == 0 || $urandom_range(99) < 2);
      end
      sent += frame_len;
    end
  endtask

  // result check, receiver stalls, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $error("no beat moved for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid && !out_stall) begin
        if (pending_means.size() == 0) begin
          $error("mean_value: no beat pending, actual %0d", out_mean_value);
          errors++;
        end else begin
          exp_mean = pending_means.pop_front();
          if (out_mean_value !== exp_mean) begin
            $error("mean_value: expected %0d, actual %0d", exp_mean, out_mean_value);
            errors++;
          end
        end
      end
    end
    out_stall <= ($urandom_range(99) < rcv_stall_pct);
  end

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_pixel_value <= '0;
    in_frame_start <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_full_scale_means();
    test_width_lowered_mid_row();
    test_size_limits();
    test_random_frames(360, 32, 79);
    test_random_frames(360, 79, 32);
    test_random_frames(360, 0, 0);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    errors += pending_means.size();
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/cbm_pkg.sv
hw/rtl/cbm_div.sv
hw/rtl/causal_box_mean_filter.sv
hw/rtl/cbm_chk.sv
verif/causal_box_mean_filter_tb.sv
